// ----- hdl/lri_pkg.sv -----
// ----------------------------------------------------------------------------
// lri_pkg
// Shared widths, register codes and types for the linear-interpolation
// resampler.
// ----------------------------------------------------------------------------
package lri_pkg;

    // Sample and phase formats
    localparam int SAMPLE_BITS      = 24;
    localparam int FRAC_BITS        = 16;
    localparam int MAX_RATIO        = 16;
    localparam int IO_CHANNELS      = 4;
    localparam int CHANNELS_DEFAULT = 4;

    localparam int PHASE_ONE  = 1 << FRAC_BITS;
    localparam int PHASE_HALF = 1 << (FRAC_BITS - 1);
    localparam int PHASE_W    = $clog2(PHASE_ONE * (MAX_RATIO + 1));
    localparam int COUNT_W    = $clog2(MAX_RATIO);
    localparam int PROD_W     = SAMPLE_BITS + FRAC_BITS + 2;

    // Configuration registers
    localparam int STEP_BITS   = 21;
    localparam int CHCNT_BITS  = 3;
    localparam int NCH_W       = CHCNT_BITS + 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = STEP_BITS;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP          = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = CFG_INDEX_W'(1);

    localparam logic [STEP_BITS-1:0]  STEP_RESET  = STEP_BITS'(65536);
    localparam logic [CHCNT_BITS-1:0] CHCNT_RESET = CHCNT_BITS'(2);

    // Step clamp limits
    localparam int STEP_MIN = PHASE_ONE / MAX_RATIO;
    localparam int STEP_MAX = PHASE_ONE * MAX_RATIO;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [PHASE_W-1:0]            phase_t;
    typedef logic [FRAC_BITS-1:0]          frac_t;

    // Control that travels alongside one output frame through the lanes
    typedef struct packed {
        logic valid;
        logic last;
    } slot_t;

endpackage

// ----- hdl/lri_if.sv -----
// ----------------------------------------------------------------------------
// lri_if
// Valid/ready channels of the resampler: input frame, output frame and
// configuration write.
// ----------------------------------------------------------------------------
interface lri_in_if import lri_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
    sample_t sample_ch3;

    modport source (output valid, input ready,
                    output sample_ch0, output sample_ch1,
                    output sample_ch2, output sample_ch3);
    modport sink   (input valid, output ready,
                    input sample_ch0, input sample_ch1,
                    input sample_ch2, input sample_ch3);
endinterface

interface lri_out_if import lri_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t out_ch0;
    sample_t out_ch1;
    sample_t out_ch2;
    sample_t out_ch3;
    logic    last_of_run;

    modport source (output valid, input ready,
                    output out_ch0, output out_ch1, output out_ch2,
                    output out_ch3, output last_of_run);
    modport sink   (input valid, output ready,
                    input out_ch0, input out_ch1, input out_ch2,
                    input out_ch3, input last_of_run);
endinterface

interface lri_cfg_if import lri_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, input ready, output index, output data);
    modport sink   (input valid, output ready, input index, input data);
endinterface

// ----- hdl/linear_interp_resampler.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Multichannel linear-interpolation sample rate converter, one multiplier
// lane per channel.
// ----------------------------------------------------------------------------
// Path: sequencer registers, lane stage one, lane stage two, output register.
// Throughput: one output frame per cycle through the per-channel multiply and
//   round pipeline while the output is not stalled; in_ready stays low while
//   an input's n results (n <= 16) are issued, high for an input giving none.
// Reset: rst_n low clears frames to zero, phase to one, step to one and
//   channel_count to 2; the first input after reset gives no output.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lri_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    lri_in_if.sink    in_ch,
    lri_out_if.source out_ch,
    lri_cfg_if.sink   cfg
);

    logic [STEP_BITS-1:0]  step_reg;
    logic [CHCNT_BITS-1:0] chan_reg;
    slot_t                 ctl1_reg;
    slot_t                 ctl2_reg;

    logic             advance;
    logic             busy;
    logic             in_fire;
    logic [NCH_W-1:0] nch;
    slot_t            issue;
    frac_t            frac;
    sample_t          in_raw [IO_CHANNELS];
    sample_t          in_frame [CHANNELS];
    sample_t          prev_frame [CHANNELS];
    sample_t          cur_frame [CHANNELS];
    sample_t          lane_y [CHANNELS];

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            chan_reg <= CHCNT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_STEP:          step_reg <= cfg.data[STEP_BITS-1:0];
                CFG_CHANNEL_COUNT: chan_reg <= cfg.data[CHCNT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Effective channel count
    always_comb
    begin
        if (chan_reg == '0)
            nch = NCH_W'(1);
        else if (NCH_W'(chan_reg) > NCH_W'(CHANNELS))
            nch = NCH_W'(CHANNELS);
        else
            nch = NCH_W'(chan_reg);
    end

    // Map the input transaction onto the lanes
    assign in_raw[0] = in_ch.sample_ch0;
    assign in_raw[1] = in_ch.sample_ch1;
    assign in_raw[2] = in_ch.sample_ch2;
    assign in_raw[3] = in_ch.sample_ch3;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_in
        if (i < IO_CHANNELS)
        begin : g_port
            assign in_frame[i] = in_raw[i];
        end
        else
        begin : g_none
            assign in_frame[i] = '0;
        end
    end

    assign in_ch.ready = !busy;
    assign in_fire     = in_ch.valid && !busy;
    assign advance     = !out_ch.valid || out_ch.ready;

    lri_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_frame   (in_frame),
        .step       (step_reg),
        .advance    (advance),
        .busy       (busy),
        .issue      (issue),
        .frac       (frac),
        .prev_frame (prev_frame),
        .cur_frame  (cur_frame)
    );

    // Carry slot control alongside the lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        lri_lane u_lane (
            .clk  (clk),
            .en   (advance),
            .prev (prev_frame[i]),
            .cur  (cur_frame[i]),
            .frac (frac),
            .y    (lane_y[i])
        );
    end

    lri_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .slot    (ctl2_reg),
        .lane_y  (lane_y),
        .nch     (nch),
        .out_ch  (out_ch)
    );

endmodule

// ----- hdl/lri_seq.sv -----
// ----------------------------------------------------------------------------
// lri_seq
// Phase sequencer: holds the previous and current frames and the phase, and
// issues one interpolation slot per advancing cycle while the phase is
// below one.
// ----------------------------------------------------------------------------
module lri_seq import lri_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  sample_t              in_frame [CHANNELS],
    input  logic [STEP_BITS-1:0] step,
    input  logic                 advance,
    output logic                 busy,
    output slot_t                issue,
    output frac_t                frac,
    output sample_t              prev_frame [CHANNELS],
    output sample_t              cur_frame [CHANNELS]
);

    logic               busy_reg;
    phase_t             phase_reg;
    logic [COUNT_W-1:0] count_reg;
    sample_t            prev_reg [CHANNELS];
    sample_t            cur_reg  [CHANNELS];

    phase_t step_eff;
    phase_t phase_sum;
    logic   issue_go;
    logic   last_now;
    logic   sum_over;

    // Clamp the step to the supported ratio range
    always_comb
    begin
        if (step < STEP_BITS'(STEP_MIN))
            step_eff = PHASE_W'(STEP_MIN);
        else if (step > STEP_BITS'(STEP_MAX))
            step_eff = PHASE_W'(STEP_MAX);
        else
            step_eff = PHASE_W'(step);
    end

    assign phase_sum = phase_reg + step_eff;
    assign sum_over  = (phase_sum >= PHASE_W'(PHASE_ONE));
    assign issue_go  = busy_reg && advance;
    assign last_now  = sum_over || (count_reg == COUNT_W'(MAX_RATIO - 1));

    // Advance the phase and run counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PHASE_W'(PHASE_ONE);
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            if (phase_reg >= PHASE_W'(PHASE_ONE))
                phase_reg <= phase_reg - PHASE_W'(PHASE_ONE);
            else
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
        end
        else if (issue_go)
        begin
            if (last_now)
            begin
                busy_reg  <= 1'b0;
                phase_reg <= sum_over ? phase_sum - PHASE_W'(PHASE_ONE) : phase_sum;
            end
            else
            begin
                phase_reg <= phase_sum;
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    // Shift the frame history on each input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
        end
        else if (in_fire)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_reg[i] <= cur_reg[i];
                cur_reg[i]  <= in_frame[i];
            end
        end
    end

    assign busy        = busy_reg;
    assign issue.valid = issue_go;
    assign issue.last  = last_now;
    assign frac        = phase_reg[FRAC_BITS-1:0];
    assign prev_frame  = prev_reg;
    assign cur_frame   = cur_reg;

endmodule

// ----- hdl/lri_lane.sv -----
// ----------------------------------------------------------------------------
// lri_lane
// One channel of the interpolator: multiply the frame difference by the
// phase fraction, then round half up and add back the previous sample.
// ----------------------------------------------------------------------------
module lri_lane import lri_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  sample_t prev,
    input  sample_t cur,
    input  frac_t   frac,
    output sample_t y
);

    logic signed [PROD_W-1:0]      prod_reg;
    sample_t                       base_reg;
    sample_t                       y_reg;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      rnd;
    logic signed [PROD_W-1:0]      quo;
    logic signed [SAMPLE_BITS+1:0] y_next;

    assign diff      = $signed({cur[SAMPLE_BITS-1], cur}) -
                       $signed({prev[SAMPLE_BITS-1], prev});
    assign prod_next = diff * $signed({1'b0, frac});

    // Stage one: product and base sample
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            base_reg <= prev;
        end
    end

    // Round half up toward plus infinity, then add the base
    assign rnd    = prod_reg + $signed(PROD_W'(PHASE_HALF));
    assign quo    = rnd >>> FRAC_BITS;
    assign y_next = $signed({{2{base_reg[SAMPLE_BITS-1]}}, base_reg}) +
                    $signed(quo[SAMPLE_BITS+1:0]);

    // Stage two: lane result
    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next[SAMPLE_BITS-1:0];
    end

    assign y = y_reg;

endmodule

// ----- hdl/lri_merge.sv -----
// ----------------------------------------------------------------------------
// lri_merge
// Output stage: gathers the lane results into one frame, zeroes the channels
// not in use and holds the frame until the sink takes it.
// ----------------------------------------------------------------------------
module lri_merge import lri_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  slot_t            slot,
    input  sample_t          lane_y [CHANNELS],
    input  logic [NCH_W-1:0] nch,
    lri_out_if.source        out_ch
);

    logic    valid_reg;
    logic    last_reg;
    sample_t data_reg [IO_CHANNELS];
    sample_t data_next [IO_CHANNELS];

    // Select lane results for the channels in use
    for (genvar j = 0; j < IO_CHANNELS; j++)
    begin : g_sel
        if (j < CHANNELS)
        begin : g_lane
            assign data_next[j] = (NCH_W'(j) < nch) ? lane_y[j] : '0;
        end
        else
        begin : g_zero
            assign data_next[j] = '0;
        end
    end

    // Hold the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= slot.valid;
    end

    // Load the output frame
    always_ff @(posedge clk)
    begin
        if (advance && slot.valid)
        begin
            last_reg <= slot.last;
            for (int j = 0; j < IO_CHANNELS; j++)
                data_reg[j] <= data_next[j];
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.last_of_run = last_reg;
    assign out_ch.out_ch0     = data_reg[0];
    assign out_ch.out_ch1     = data_reg[1];
    assign out_ch.out_ch2     = data_reg[2];
    assign out_ch.out_ch3     = data_reg[3];

endmodule

// ----- hdl/lri_checker.sv -----
// ----------------------------------------------------------------------------
// lri_checker
// Port-level checks of the resampler handshakes and run sequencing.
// ----------------------------------------------------------------------------
module lri_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);

    // Hold an output transaction until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // A run continues back to back until its last frame
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap inside an output run");

    // Input stalls only after taking an input transaction
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("input ready dropped without an input transaction");

endmodule

bind linear_interp_resampler lri_checker u_lri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last_of_run)
);
